// ===== hw/rtl/ppro_pkg.sv =====
// package: constants, types and function codes of the planar pixel raster op block
`default_nettype none
package ppro_pkg;

  localparam int ROW_BYTES   = 80;
  localparam int PLANE_BYTES = 65536;
  localparam int PLANES      = 4;

  localparam int FUNC_W  = 3;
  localparam int POS_W   = 10;
  localparam int PIX_W   = 8;
  localparam int PAGE_W  = 16;
  localparam int OFF_W   = $clog2(PLANE_BYTES);
  localparam int PLANE_W = $clog2(PLANES);
  localparam int ROW_W   = PLANES * PIX_W;

  localparam int SUM_MAX = ((1 << PAGE_W) - 1) + ((1 << POS_W) - 1) * ROW_BYTES
                         + ((1 << POS_W) - 1) / PLANES;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  typedef logic [OFF_W-1:0]   off_t;
  typedef logic [PLANE_W-1:0] plane_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [ROW_W-1:0]   row_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ    = 3'd0,
    FUNC_REPLACE = 3'd1,
    FUNC_XOR     = 3'd2,
    FUNC_OR      = 3'd3,
    FUNC_AND     = 3'd4,
    FUNC_INV     = 3'd5
  } func_e;

  typedef struct packed {
    logic   en;
    off_t   off;
    plane_t plane;
    pix_t   data;
  } wr_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ppro_if.sv =====
// interfaces: pixel request, result and page offset channels
`default_nettype none
interface ppro_in_if;
  import ppro_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  pix_t              color;
  modport source (output valid, func, pos_x, pos_y, color, input ready);
  modport sink   (input valid, func, pos_x, pos_y, color, output ready);
endinterface

interface ppro_out_if;
  import ppro_pkg::*;
  logic valid;
  logic ready;
  pix_t old_pixel;
  modport source (output valid, old_pixel, input ready);
  modport sink   (input valid, old_pixel, output ready);
endinterface

interface ppro_cfg_if;
  import ppro_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ppro_vmem.sv =====
// frame store: plane-interleaved byte memory with clearing sweep after reset
`default_nettype none
module ppro_vmem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  ppro_pkg::off_t   rd_off_i,
  output ppro_pkg::row_t   rd_row_o,
  input  ppro_pkg::wr_req_t wr_i,
  output logic             busy_o
);
  import ppro_pkg::*;

  row_t mem [PLANE_BYTES];
  row_t rd_row_q;
  logic clr_busy_q;
  off_t clr_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_off_q  <= '0;
    end else if (clr_busy_q) begin
      clr_off_q <= clr_off_q + 1'b1;
      if (clr_off_q == OFF_W'(PLANE_BYTES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_off_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.off][wr_i.plane*PIX_W +: PIX_W] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_off_i];
    end
  end

  assign rd_row_o = rd_row_q;
  assign busy_o   = clr_busy_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ppro_rop.sv =====
// raster op unit: combines color with the old byte per function code
`default_nettype none
module ppro_rop (
  input  logic [ppro_pkg::FUNC_W-1:0] func_i,
  input  ppro_pkg::pix_t              color_i,
  input  ppro_pkg::pix_t              old_i,
  output logic                        we_o,
  output ppro_pkg::pix_t              new_o
);
  import ppro_pkg::*;

  always_comb begin
    we_o  = 1'b1;
    new_o = old_i;
    case (func_e'(func_i))
      FUNC_REPLACE: new_o = color_i;
      FUNC_XOR:     new_o = color_i ^ old_i;
      FUNC_OR:      new_o = color_i | old_i;
      FUNC_AND:     new_o = color_i & old_i;
      FUNC_INV:     new_o = ~color_i;
      default: begin
        we_o  = 1'b0;
        new_o = old_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/planar_pixel_raster_op.sv =====
// top level: four-plane frame store with per-pixel read-modify-write raster ops
// an accepted word is held in the b stage, then its old byte in the result register
// one word per cycle while res_o is ready; a write forward covers the stale memory read
// reset: page offset clears to zero, then the store is swept to zero one row a cycle,
// 65536 rows, with the request channel not ready; page offset writes are taken throughout
`default_nettype none
module planar_pixel_raster_op (
  input  logic  clk_i,
  input  logic  rst_ni,
  ppro_cfg_if.sink   cfg_i,
  ppro_in_if.sink    pix_i,
  ppro_out_if.source res_o
);
  import ppro_pkg::*;

  logic [PAGE_W-1:0] page_q;
  logic [SUM_W-1:0]  sum;
  off_t              off;
  plane_t            plane;

  logic              clr_busy;
  logic              in_fire;
  logic              b_fire;
  logic              b_valid_q, b_valid_d;
  off_t              b_off_q;
  plane_t            b_plane_q;
  logic [FUNC_W-1:0] b_func_q;
  pix_t              b_color_q;

  row_t              rd_row;
  pix_t              mem_byte;
  pix_t              old_byte;
  pix_t              new_byte;
  logic              rop_we;
  logic              fwd_hit;
  wr_req_t           wr_req;
  wr_req_t           byp_q;

  logic              out_valid_q, out_valid_d;
  pix_t              old_pixel_q;

  // page offset
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      page_q <= cfg_i.data;
    end
  end

  // address
  assign sum   = SUM_W'(page_q) + SUM_W'(pix_i.pos_y) * SUM_W'(ROW_BYTES)
               + SUM_W'(pix_i.pos_x >> PLANE_W);
  assign off   = sum[OFF_W-1:0];
  assign plane = pix_i.pos_x[PLANE_W-1:0];

  // handshake
  assign b_fire      = b_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !clr_busy && (!b_valid_q || b_fire);
  assign in_fire     = pix_i.valid && pix_i.ready;

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_fire) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_fire) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= '0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_req.en) begin
        byp_q <= wr_req;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_off_q   <= off;
      b_plane_q <= plane;
      b_func_q  <= pix_i.func;
      b_color_q <= pix_i.color;
    end
    if (b_fire) begin
      old_pixel_q <= old_byte;
    end
  end

  ppro_vmem u_vmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_off_i (off),
    .rd_row_o (rd_row),
    .wr_i     (wr_req),
    .busy_o   (clr_busy)
  );

  // forward the last write over the stale read
  assign mem_byte = rd_row[b_plane_q*PIX_W +: PIX_W];
  assign fwd_hit  = byp_q.en && (byp_q.off == b_off_q) && (byp_q.plane == b_plane_q);
  assign old_byte = fwd_hit ? byp_q.data : mem_byte;

  ppro_rop u_rop (
    .func_i  (b_func_q),
    .color_i (b_color_q),
    .old_i   (old_byte),
    .we_o    (rop_we),
    .new_o   (new_byte)
  );

  assign wr_req.en    = b_fire && rop_we;
  assign wr_req.off   = b_off_q;
  assign wr_req.plane = b_plane_q;
  assign wr_req.data  = new_byte;

  assign res_o.valid     = out_valid_q;
  assign res_o.old_pixel = old_pixel_q;

`ifndef SYNTHESIS
  ap_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !(pix_i.valid && pix_i.ready))
    else $error("request accepted during clearing sweep");

  ap_fwd_same_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_req.en && in_fire && (off == wr_req.off) && (plane == wr_req.plane)) |=> fwd_hit)
    else $error("back-to-back access to one byte not forwarded");

  ap_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_fire) |=> (b_valid_q && $stable(b_off_q) && $stable(b_plane_q)))
    else $error("stalled word lost its address");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// testbench: planar_pixel_raster_op pixel words checked against a four-plane frame store predictor
`default_nettype none
module tb;
  import ppro_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 190;
  localparam int HOT_SPOTS     = 8;
  localparam int STALL_AT      = 300;
  localparam int STALL_CYCLES  = 80;
  localparam int DRAIN_CYCLES  = 2000;
  localparam int MAX_SHOWN     = 40;
  localparam int LIMIT_CYCLES  = 1000000;

  // function codes the block treats as a plain read
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    pix_t              color;
  } pix_req_t;

  logic clk_i;
  logic rst_ni;

  ppro_cfg_if cfg_if ();
  ppro_in_if  pix_if ();
  ppro_out_if res_if ();

  planar_pixel_raster_op i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  pix_t              frame_mem [PLANES*PLANE_BYTES];
  logic [PAGE_W-1:0] page_model;
  pix_req_t          pix_req_q [$];
  pix_t              old_pixel_q [$];
  int unsigned       words_sent;
  int unsigned       words_taken;
  int unsigned       results_seen;
  int unsigned       mismatches;
  int unsigned       pages_used;
  int                tx_gap;
  int                rx_gap;
  int                stall_left;
  bit                stall_done;
  bit                calm;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // returns the byte before the access and applies the raster op to the frame store
  function automatic pix_t apply_pixel_op(input pix_req_t r);
    int   sum;
    int   addr;
    pix_t old;
    pix_t nv;
    sum  = int'(page_model) + int'(r.pos_y) * ROW_BYTES + int'(r.pos_x >> PLANE_W);
    addr = int'(r.pos_x[PLANE_W-1:0]) * PLANE_BYTES + sum % PLANE_BYTES;
    old  = frame_mem[addr];
    case (r.func)
      FUNC_REPLACE: nv = r.color;
      FUNC_XOR:     nv = r.color ^ old;
      FUNC_OR:      nv = r.color | old;
      FUNC_AND:     nv = r.color & old;
      FUNC_INV:     nv = ~r.color;
      default:      nv = old;
    endcase
    frame_mem[addr] = nv;
    return old;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch: %s", what);
  endtask

  task automatic queue_word(input logic [FUNC_W-1:0] func, input int x, input int y,
                            input int color);
    pix_req_t r;
    r.func  = func;
    r.pos_x = POS_W'(x);
    r.pos_y = POS_W'(y);
    r.color = PIX_W'(color);
    pix_req_q.push_back(r);
  endtask

  task automatic write_page(input logic [PAGE_W-1:0] page);
    @(negedge clk_i);
    cfg_if.data  <= page;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    page_model = page;
    pages_used++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pix_req_q.size() != 0 || words_taken != words_sent || old_pixel_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // driver: take accepted words into the predictor
  always @(posedge clk_i) begin : take_words
    pix_req_t r;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      r = {pix_if.func, pix_if.pos_x, pix_if.pos_y, pix_if.color};
      old_pixel_q.push_back(apply_pixel_op(r));
      words_taken++;
    end
  end

  // driver: offer the next word once the current one is taken
  always @(negedge clk_i) begin : offer_words
    pix_req_t r;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (words_taken == words_sent) begin
      if (tx_gap != 0) begin
        tx_gap       <= tx_gap - 1;
        pix_if.valid <= 1'b0;
      end else if (pix_req_q.size() != 0) begin
        r = pix_req_q.pop_front();
        pix_if.func  <= r.func;
        pix_if.pos_x <= r.pos_x;
        pix_if.pos_y <= r.pos_y;
        pix_if.color <= r.color;
        pix_if.valid <= 1'b1;
        words_sent   <= words_sent + 1;
        tx_gap       <= pick_gap();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(negedge clk_i) begin
    if (!stall_done && words_taken >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor: result ready
  always @(negedge clk_i) begin
    if (!rst_ni || stall_left != 0) begin
      res_if.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap       <= rx_gap - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      rx_gap       <= pick_gap();
    end
  end

  // monitor: compare result words in order
  always @(posedge clk_i) begin : check_words
    pix_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (old_pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word old_pixel=%02h", res_if.old_pixel));
      end else begin
        want = old_pixel_q.pop_front();
        if (res_if.old_pixel !== want)
          report_mismatch($sformatf("word %0d old_pixel=%02h, want %02h",
                                    results_seen, res_if.old_pixel, want));
      end
    end
  end

  initial begin : run
    int hot_x [HOT_SPOTS];
    int hot_y [HOT_SPOTS];
    int last_x;
    int last_y;
    int k;
    int x;
    int y;
    logic [PAGE_W-1:0] page;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    pix_if.valid = 1'b0;
    pix_if.func  = '0;
    pix_if.pos_x = '0;
    pix_if.pos_y = '0;
    pix_if.color = '0;
    res_if.ready = 1'b0;
    tx_gap       = 0;
    rx_gap       = 0;
    stall_left   = 0;
    stall_done   = 1'b0;
    calm         = 1'b0;
    page_model   = '0;
    for (int i = 0; i < PLANES*PLANE_BYTES; i++) frame_mem[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // page write goes in while the store is still being cleared
    write_page(16'h0000);

    // all functions on one byte, one after another
    queue_word(FUNC_READ,    0, 0, 8'h00);
    queue_word(FUNC_REPLACE, 0, 0, 8'hFF);
    queue_word(FUNC_READ,    0, 0, 8'h00);
    queue_word(FUNC_XOR,     0, 0, 8'h0F);
    queue_word(FUNC_OR,      0, 0, 8'h0F);
    queue_word(FUNC_AND,     0, 0, 8'hA5);
    queue_word(FUNC_INV,     0, 0, 8'h5A);
    queue_word(FUNC_SPARE_A, 0, 0, 8'hFF);
    queue_word(FUNC_SPARE_B, 0, 0, 8'h00);
    queue_word(FUNC_READ,    0, 0, 8'hFF);
    // far corner, offset wraps
    queue_word(FUNC_REPLACE, 1023, 1023, 8'hFF);
    queue_word(FUNC_READ,    1023, 1023, 8'h00);
    // same offset in each plane
    queue_word(FUNC_REPLACE, 1, 0, 8'h42);
    queue_word(FUNC_REPLACE, 2, 0, 8'h24);
    queue_word(FUNC_REPLACE, 3, 0, 8'h81);
    queue_word(FUNC_READ,    1, 0, 8'h00);
    queue_word(FUNC_READ,    2, 0, 8'h00);
    queue_word(FUNC_READ,    3, 0, 8'h00);
    // wrapped sum lands back on the first byte
    queue_word(FUNC_READ,    64, 819, 8'h00);
    queue_word(FUNC_XOR,     64, 819, 8'hFF);
    queue_word(FUNC_READ,    0, 0, 8'h00);
    queue_word(FUNC_REPLACE, 1020, 0, 8'h00);
    queue_word(FUNC_READ,    0, 1023, 8'h00);
    wait_idle();

    last_x = 0;
    last_y = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       page = 16'hFFFF;
        1:       page = 16'h0000;
        3:       page = 16'h8000;
        default: page = PAGE_W'($urandom);
      endcase
      write_page(page);
      calm = (ph == 2);
      for (int h = 0; h < HOT_SPOTS; h++) begin
        hot_x[h] = $urandom_range(0, 1023);
        hot_y[h] = $urandom_range(0, 1023);
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k = $urandom_range(0, 4);
        if (k < 3) begin
          k = $urandom_range(0, HOT_SPOTS - 1);
          x = hot_x[k];
          y = hot_y[k];
        end else if (k == 3) begin
          x = last_x;
          y = last_y;
        end else begin
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
        end
        queue_word(FUNC_W'($urandom_range(0, 7)), x, y, $urandom_range(0, 255));
        last_x = x;
        last_y = y;
      end
      wait_idle();
    end

    for (int i = 0; i < DRAIN_CYCLES && (words_taken != words_sent || old_pixel_q.size() != 0);
         i++)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (old_pixel_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", old_pixel_q.size()));

    $display("run covered %0d pixel words, all eight function codes, wrapped offsets, %0d page writes",
             words_taken, pages_used);
    $display("%0d old pixel words checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** planar_pixel_raster_op: PASSED **");
    end else begin
      $display("** planar_pixel_raster_op: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout waiting for pixel words");
    $display("** planar_pixel_raster_op: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
